@@ rtl/core/pru_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pru_pkg
// Shared types and constants for the pixel replication upscaler: transaction
// payload structures, configuration register indexes and operation codes.
// ----------------------------------------------------------------------------
package pru_pkg;

    // Default store and image limits.
    localparam int PRU_MAX_WIDTH  = 1024;
    localparam int PRU_MAX_HEIGHT = 4096;

    // Configuration register widths.
    localparam int SCALE_W    = 7;
    localparam int IN_WIDTH_W = 11;
    localparam int IN_HEIGHT_W = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;

    // Largest repeat count; larger factors saturate to it.
    localparam logic [SCALE_W-1:0] FACTOR_LIMIT = 7'd100;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_FACTOR = 2'd0,
        CFG_IN_WIDTH     = 2'd1,
        CFG_IN_HEIGHT    = 2'd2
    } cfg_index_t;

    // Operation codes of an input transaction.
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // Input transaction payload.
    typedef struct packed {
        logic [0:0] opcode;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic [1:0] pad_bytes;
        logic [0:0] row_end;
        logic [0:0] image_end;
        logic [0:0] rejected;
    } out_item_t;

endpackage
`default_nettype wire

@@ rtl/core/pixel_replication_upscaler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Latency: a result appears on m_valid in the cycle after its input transaction is accepted.
// Throughput: one input transaction per clock; s_ready drops only while a result is held
// and m_ready is low, set by the single result register beside the row store read register.
// Reset (aresetn low, synchronous) clears all counters and the result valid, and loads the
// configuration registers with 1; the row store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// pixel_replication_upscaler
// Integer nearest-neighbor upscaler for 24-bit pixels. Pushes fill a row store;
// ticks replay each stored pixel scale_factor times across a row and the whole
// row scale_factor times, flagging row end, padding bytes and image end.
// ----------------------------------------------------------------------------
module pixel_replication_upscaler
    import pru_pkg::*;
#(
    parameter int MAX_WIDTH  = PRU_MAX_WIDTH,
    parameter int MAX_HEIGHT = PRU_MAX_HEIGHT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_data,
    // Result channel
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_data
);

    localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [SCALE_W-1:0]     scale_factor_reg;
    logic [IN_WIDTH_W-1:0]  in_width_reg;
    logic [IN_HEIGHT_W-1:0] in_height_reg;

    // Control state.
    logic [WCNT_W-1:0]  fill_column_reg, fill_column_next;
    logic               replaying_reg, replaying_next;
    logic [AW-1:0]      read_column_reg, read_column_next;
    logic [SCALE_W-1:0] h_repeat_reg, h_repeat_next;
    logic [SCALE_W-1:0] v_repeat_reg, v_repeat_next;
    logic [RW-1:0]      rows_done_reg, rows_done_next;

    // Result register.
    logic       m_valid_reg, m_valid_next;
    logic       pixel_reg, pixel_next;
    logic [1:0] pad_reg, pad_next;
    logic       row_end_reg, row_end_next;
    logic       image_end_reg, image_end_next;
    logic       rejected_reg, rejected_next;

    // Row store with registered read.
    logic [23:0] row_store [MAX_WIDTH];
    logic [23:0] rd_data_reg;

    // Effective configuration values and helpers.
    logic [SCALE_W-1:0] eff_f;
    logic [WCNT_W-1:0]  eff_w;
    logic [HCNT_W-1:0]  eff_h;
    logic [1:0]         pad_count;
    logic               accept;
    logic               is_push;
    logic               store_wr;
    logic               store_rd;
    logic [WCNT_W:0]    fill_inc;
    logic [AW:0]        col_inc;
    logic [SCALE_W:0]   h_inc;
    logic [SCALE_W:0]   v_inc;
    logic [RW:0]        rows_inc;
    logic               finish_row;

    // Saturate the configuration registers to their usable ranges.
    always_comb begin
        eff_f = (scale_factor_reg > FACTOR_LIMIT) ? FACTOR_LIMIT : scale_factor_reg;
        if (in_width_reg == '0) begin
            eff_w = WCNT_W'(1);
        end else if (32'(in_width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = WCNT_W'(MAX_WIDTH);
        end else begin
            eff_w = WCNT_W'(in_width_reg);
        end
        if (in_height_reg == '0) begin
            eff_h = HCNT_W'(1);
        end else if (32'(in_height_reg) > 32'(MAX_HEIGHT)) begin
            eff_h = HCNT_W'(MAX_HEIGHT);
        end else begin
            eff_h = HCNT_W'(in_height_reg);
        end
        // Output row bytes are 3*w*f; the padding is (w*f) mod 4.
        pad_count = 2'(2'(eff_w) * 2'(eff_f));
    end

    // Handshake: a new transaction enters whenever the result register is free.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_push = (s_data.opcode == OP_PUSH);

    // Counter increments.
    assign fill_inc = {1'b0, fill_column_reg} + 1'b1;
    assign col_inc  = {1'b0, read_column_reg} + 1'b1;
    assign h_inc    = {1'b0, h_repeat_reg} + 1'b1;
    assign v_inc    = {1'b0, v_repeat_reg} + 1'b1;
    assign rows_inc = {1'b0, rows_done_reg} + 1'b1;

    // Next state of the fill and replay counters and of the result register.
    always_comb begin
        fill_column_next = fill_column_reg;
        replaying_next   = replaying_reg;
        read_column_next = read_column_reg;
        h_repeat_next    = h_repeat_reg;
        v_repeat_next    = v_repeat_reg;
        rows_done_next   = rows_done_reg;
        finish_row       = 1'b0;
        store_wr         = 1'b0;
        store_rd         = 1'b0;
        pixel_next       = 1'b0;
        pad_next         = 2'd0;
        row_end_next     = 1'b0;
        image_end_next   = 1'b0;
        rejected_next    = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;

        if (accept) begin
            m_valid_next = 1'b0;
            if (is_push) begin
                if (replaying_reg) begin
                    // A push during replay is dropped and flagged.
                    m_valid_next  = 1'b1;
                    rejected_next = 1'b1;
                end else begin
                    store_wr         = (32'(fill_column_reg) < 32'(MAX_WIDTH));
                    fill_column_next = fill_inc[WCNT_W-1:0];
                    if (32'(fill_inc) >= 32'(eff_w)) begin
                        if (eff_f == '0) begin
                            finish_row = 1'b1;
                        end else begin
                            replaying_next   = 1'b1;
                            read_column_next = '0;
                            h_repeat_next    = '0;
                            v_repeat_next    = '0;
                        end
                    end
                end
            end else if (replaying_reg) begin
                if (eff_f == '0) begin
                    // Factor zero ends the replay without a result.
                    finish_row = 1'b1;
                end else begin
                    m_valid_next  = 1'b1;
                    pixel_next    = 1'b1;
                    store_rd      = 1'b1;
                    h_repeat_next = h_inc[SCALE_W-1:0];
                    if (h_inc >= {1'b0, eff_f}) begin
                        h_repeat_next    = '0;
                        read_column_next = col_inc[AW-1:0];
                        if (32'(col_inc) >= 32'(eff_w)) begin
                            row_end_next     = 1'b1;
                            pad_next         = pad_count;
                            read_column_next = '0;
                            v_repeat_next    = v_inc[SCALE_W-1:0];
                            if (v_inc >= {1'b0, eff_f}) begin
                                finish_row = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        // End of an input row: return to filling and count the row.
        if (finish_row) begin
            replaying_next   = 1'b0;
            fill_column_next = '0;
            read_column_next = '0;
            h_repeat_next    = '0;
            v_repeat_next    = '0;
            rows_done_next   = rows_inc[RW-1:0];
            if (32'(rows_inc) >= 32'(eff_h)) begin
                rows_done_next = '0;
                image_end_next = pixel_next;
            end
        end
    end

    // Configuration registers and control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_factor_reg <= SCALE_W'(1);
            in_width_reg     <= IN_WIDTH_W'(1);
            in_height_reg    <= IN_HEIGHT_W'(1);
            fill_column_reg  <= '0;
            replaying_reg    <= 1'b0;
            read_column_reg  <= '0;
            h_repeat_reg     <= '0;
            v_repeat_reg     <= '0;
            rows_done_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SCALE_FACTOR: scale_factor_reg <= cfg_data[SCALE_W-1:0];
                    CFG_IN_WIDTH:     in_width_reg     <= cfg_data[IN_WIDTH_W-1:0];
                    CFG_IN_HEIGHT:    in_height_reg    <= cfg_data[IN_HEIGHT_W-1:0];
                    default: ;
                endcase
            end
            fill_column_reg <= fill_column_next;
            replaying_reg   <= replaying_next;
            read_column_reg <= read_column_next;
            h_repeat_reg    <= h_repeat_next;
            v_repeat_reg    <= v_repeat_next;
            rows_done_reg   <= rows_done_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // Result payload loads with each accepted transaction.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pixel_reg     <= pixel_next;
            pad_reg       <= pad_next;
            row_end_reg   <= row_end_next;
            image_end_reg <= image_end_next;
            rejected_reg  <= rejected_next;
        end
    end

    // Row store: one write port for pushes, one registered read port for ticks.
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            row_store[fill_column_reg[AW-1:0]] <= {s_data.red, s_data.green, s_data.blue};
        end
        if (store_rd) begin
            rd_data_reg <= row_store[read_column_reg];
        end
    end

    // Result outputs; a rejected push carries a zero pixel.
    always_comb begin
        m_valid          = m_valid_reg;
        m_data.out_blue  = pixel_reg ? rd_data_reg[7:0]   : 8'd0;
        m_data.out_green = pixel_reg ? rd_data_reg[15:8]  : 8'd0;
        m_data.out_red   = pixel_reg ? rd_data_reg[23:16] : 8'd0;
        m_data.pad_bytes = pad_reg;
        m_data.row_end   = row_end_reg;
        m_data.image_end = image_end_reg;
        m_data.rejected  = rejected_reg;
    end

endmodule
`default_nettype wire
